### design/ted_pkg.sv
// Shared types, constants and character classifiers for the transfer encoding decoder.
package ted_pkg;

  localparam int OUT_BUF_BYTES = 4096;
  localparam int CNT_W         = $clog2(OUT_BUF_BYTES);
  localparam int MAX_RES       = 3;

  typedef enum logic [1:0] {
    MODE_7BIT = 2'd0,
    MODE_QP   = 2'd1,
    MODE_B64  = 2'd2
  } mode_t;

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [5:0] SX_LOWER = 6'd26;
  localparam logic [5:0] SX_DIGIT = 6'd52;
  localparam logic [5:0] SX_PLUS  = 6'd62;
  localparam logic [5:0] SX_SLASH = 6'd63;

  typedef struct packed {
    logic [1:0]       pend_cnt;
    logic [7:0]       pend_sec;
    logic [11:0]      acc;
    logic [3:0]       held;
    logic             stopped;
    logic [CNT_W-1:0] emitted;
  } dec_state_t;

  typedef struct packed {
    logic [1:0]                 cnt;
    logic [MAX_RES-1:0][7:0]    bytes;
  } dec_res_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  // {valid, sextet}
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = {1'b1, 6'(c - 8'h61) + SX_LOWER};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 6'(c - 8'h30) + SX_DIGIT};
    end else if (c == CH_PLUS) begin
      r = {1'b1, SX_PLUS};
    end else if (c == CH_SLASH) begin
      r = {1'b1, SX_SLASH};
    end
    return r;
  endfunction

endpackage

### design/ted_decode.sv
// Per-byte decode step: next state and up to three result bytes.
module ted_decode
  import ted_pkg::*;
(
  input  logic [1:0] mode,
  input  dec_state_t st,
  input  logic [7:0] data_byte,
  input  logic       range_end,
  output dec_state_t st_nxt,
  output dec_res_t   res
);

  logic [MAX_RES-1:0][7:0] raw;
  logic [1:0]              n;
  dec_state_t              s;
  logic [4:0]              hi;
  logic [4:0]              lo;
  logic [6:0]              sx;
  logic [3:0]              hb;
  logic [11:0]             acc_n;
  logic [CNT_W-1:0]        room;
  logic [CNT_W+1:0]        room_x;
  logic [1:0]              k;

  always_comb begin
    raw   = '0;
    n     = 2'd0;
    s     = st;
    hi    = hex_of(st.pend_sec);
    lo    = hex_of(data_byte);
    sx    = sextet_of(data_byte);
    hb    = st.held + 4'd6;
    acc_n = {st.acc[5:0], sx[5:0]};

    case (mode)
      MODE_QP: begin
        case (st.pend_cnt)
          2'd0: begin
            if (data_byte == CH_EQ) begin
              s.pend_cnt = 2'd1;
            end else begin
              raw[n] = data_byte;
              n = n + 2'd1;
            end
          end
          2'd1: begin
            if (data_byte == CH_LF) begin
              s.pend_cnt = 2'd0;
            end else if (lo[4] || data_byte == CH_CR) begin
              s.pend_sec = data_byte;
              s.pend_cnt = 2'd2;
            end else begin
              raw[n] = CH_EQ;
              n = n + 2'd1;
              s.pend_cnt = 2'd0;
              if (data_byte == CH_EQ) begin
                s.pend_cnt = 2'd1;
              end else begin
                raw[n] = data_byte;
                n = n + 2'd1;
              end
            end
          end
          default: begin
            s.pend_cnt = 2'd0;
            s.pend_sec = 8'd0;
            if (hi[4] && lo[4]) begin
              raw[n] = {hi[3:0], lo[3:0]};
              n = n + 2'd1;
            end else if (!(st.pend_sec == CH_CR && data_byte == CH_LF)) begin
              raw[n] = CH_EQ;
              n = n + 2'd1;
              raw[n] = st.pend_sec;
              n = n + 2'd1;
              if (data_byte == CH_EQ) begin
                s.pend_cnt = 2'd1;
              end else begin
                raw[n] = data_byte;
                n = n + 2'd1;
              end
            end
          end
        endcase
        if (range_end) begin
          if (s.pend_cnt != 2'd0) begin
            raw[n] = CH_EQ;
            n = n + 2'd1;
          end
          if (s.pend_cnt == 2'd2) begin
            raw[n] = s.pend_sec;
            n = n + 2'd1;
          end
        end
      end
      MODE_B64: begin
        if (!st.stopped) begin
          if (data_byte == CH_EQ) begin
            s.stopped = 1'b1;
          end else if (sx[6]) begin
            s.acc = acc_n;
            if (hb >= 4'd8) begin
              s.held = hb - 4'd8;
              raw[n] = 8'(acc_n >> s.held);
              n = n + 2'd1;
            end else begin
              s.held = hb;
            end
          end
        end
      end
      default: begin
        raw[n] = data_byte;
        n = n + 2'd1;
      end
    endcase

    // cut at the buffer limit
    room   = CNT_W'(OUT_BUF_BYTES - 1) - st.emitted;
    room_x = (CNT_W+2)'(room);
    if (room_x < (CNT_W+2)'(n)) begin
      k = room_x[1:0];
    end else begin
      k = n;
    end
    s.emitted = st.emitted + CNT_W'(k);

    if (range_end) begin
      s = '0;
    end

    st_nxt    = s;
    res.cnt   = k;
    res.bytes = raw;
  end

endmodule

### design/transfer_encoding_decoder.sv
// Top level of the transfer encoding decoder: input register, decode step, result queue.
// Flow: an accepted byte waits in the input register and is decoded as it loads the result
// queue, whose first result is then presented. Throughput: one byte per cycle while out_ready
// holds and each byte yields at most one result; a byte with more results holds the output
// until all are taken and stalls the input meanwhile, as the single output port drains the queue.
// Reset: synchronous active-low rst_n clears the mode, the decode state and both stages.
module transfer_encoding_decoder
  import ted_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_range_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last
);

  logic [1:0]              mode_r;
  logic                    in_vld_r;
  logic [7:0]              in_byte_r;
  logic                    in_end_r;
  dec_state_t              st_r;
  dec_state_t              st_nxt;
  dec_res_t                res;
  logic [1:0]              ob_cnt_r;
  logic [1:0]              ob_cnt_nxt;
  logic [MAX_RES-1:0][7:0] ob_byte_r;
  logic [MAX_RES-1:0][7:0] ob_byte_nxt;
  logic                    pop;
  logic                    load;

  ted_decode u_decode (
    .mode      (mode_r),
    .st        (st_r),
    .data_byte (in_byte_r),
    .range_end (in_end_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  assign out_valid    = (ob_cnt_r != 2'd0);
  assign out_byte     = ob_byte_r[0];
  assign out_run_last = (ob_cnt_r == 2'd1);
  assign pop          = out_valid && out_ready;
  assign load         = in_vld_r && (ob_cnt_r == 2'd0 || (ob_cnt_r == 2'd1 && pop));
  assign in_ready     = !in_vld_r || load;

  always_comb begin
    ob_cnt_nxt  = ob_cnt_r;
    ob_byte_nxt = ob_byte_r;
    if (load) begin
      ob_cnt_nxt  = res.cnt;
      ob_byte_nxt = res.bytes;
    end else if (pop) begin
      ob_cnt_nxt  = ob_cnt_r - 2'd1;
      ob_byte_nxt = {8'd0, ob_byte_r[MAX_RES-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_7BIT;
      in_vld_r <= 1'b0;
      st_r     <= '0;
      ob_cnt_r <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (load) begin
        st_r <= st_nxt;
      end
      ob_cnt_r <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
      in_end_r  <= in_range_end;
    end
    ob_byte_r <= ob_byte_nxt;
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load && in_end_r) |=> (st_r.emitted == '0 && st_r.pend_cnt == 2'd0 && !st_r.stopped))
    else $error("decode state not cleared after range end");

  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pend_cnt != 2'd3)
    else $error("quoted-printable pending count out of range");

  a_held_even: assert property (@(posedge clk) disable iff (!rst_n)
    (!st_r.held[0] && st_r.held < 4'd8))
    else $error("base64 held bit count invalid");

  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W+1)'(st_r.emitted) < (CNT_W+1)'(OUT_BUF_BYTES))
    else $error("emitted count past buffer limit");

  a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (ob_cnt_r > 2'd1) |-> !in_ready || !in_vld_r)
    else $error("input taken while results still queued");

endmodule
